/* hdl/hsct_pkg.sv */
`default_nettype none

package hsct_pkg;

  localparam int SecW    = 15;
  localparam int CntW    = 16;
  localparam int CfgW    = 14;
  localparam int CfgIdxW = 1;
  localparam int FirstW  = 6;
  localparam int WinW    = 2;

  // Quotient by 60 through a reciprocal: floor(s * Recip60 / 2**RecipShift)
  // is exact for every 15-bit s.
  localparam int RecipW     = 16;
  localparam int RecipShift = 21;
  localparam int QuotW      = 10;
  localparam logic [RecipW-1:0] Recip60 = 16'd34953;

  localparam logic [WinW-1:0]   RestartTicks  = 2'd3;
  localparam logic [FirstW-1:0] MinuteSeconds = 6'd60;
  localparam logic [CntW-1:0]   SaverMax      = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_TICK           = 4'd0,
    OP_START_GENERIC  = 4'd1,
    OP_CLEAR_GENERIC  = 4'd2,
    OP_START_RUN      = 4'd3,
    OP_PAUSE          = 4'd4,
    OP_RESUME         = 4'd5,
    OP_SAVER_RESTART  = 4'd6,
    OP_SAVER_STOP     = 4'd7,
    OP_READ_GENERIC   = 4'd8,
    OP_READ_DISPLAY   = 4'd9,
    OP_READ_SELFTEST  = 4'd10
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAVER_DELAY  = 1'b0,
    CFG_SAVER_LENGTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [SecW-1:0] seconds;
  } hsct_in_t;

  typedef struct packed {
    logic            generic_done;
    logic            display_due;
    logic            selftest_due;
    logic [SecW-1:0] seconds_left;
    logic            early_interval;
    logic            newly_restarted;
    logic            saver_start;
    logic            screen_blank;
  } hsct_out_t;

  // Word held in the input register, with its quotient by 60 precomputed.
  typedef struct packed {
    logic [3:0]       op;
    logic [SecW-1:0]  seconds;
    logic [QuotW-1:0] quot;
  } hsct_stage_t;

endpackage

`default_nettype wire

/* hdl/hsct_in_stage.sv */
`default_nettype none

module hsct_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire hsct_pkg::hsct_in_t   in_word,
  output logic                      stage_valid,
  output hsct_pkg::hsct_stage_t     stage_word,
  input  wire logic                 stage_take
);
  import hsct_pkg::*;

  logic                     load;
  logic                     stage_valid_next;
  logic [SecW+RecipW-1:0]   recip_prod;

  assign in_stall         = stage_valid & ~stage_take;
  assign load             = in_valid & ~in_stall;
  assign stage_valid_next = load | (stage_valid & ~stage_take);
  assign recip_prod       = SecW'(in_word.seconds) * Recip60;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_word.op      <= in_word.op;
      stage_word.seconds <= in_word.seconds;
      stage_word.quot    <= recip_prod[RecipShift +: QuotW];
    end
  end

endmodule

`default_nettype wire

/* hdl/hsct_core.sv */
`default_nettype none

module hsct_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         stage_valid,
  input  wire hsct_pkg::hsct_stage_t        stage_word,
  output logic                              stage_take,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output hsct_pkg::hsct_out_t               out_word,
  input  wire logic                         cfg_we,
  input  wire logic [hsct_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hsct_pkg::CfgW-1:0]    cfg_data
);
  import hsct_pkg::*;

  logic fire;

  // Configuration
  logic [CfgW-1:0] cfg_delay, cfg_length;

  // Timer state
  logic [CntW-1:0]   generic_count, generic_count_next;
  logic              generic_flag, generic_flag_next;
  logic [CntW-1:0]   run_count, run_count_next;
  logic [SecW-1:0]   run_start, run_start_next;
  logic [FirstW-1:0] first_interval, first_interval_next;
  logic              run_paused, run_paused_next;
  logic [WinW-1:0]   restart_window, restart_window_next;
  logic              display_flag, display_flag_next;
  logic              selftest_flag, selftest_flag_next;
  logic              tick_phase, tick_phase_next;
  logic              saver_enabled, saver_enabled_next;
  logic [CntW-1:0]   saver_count, saver_count_next;
  logic [CntW-1:0]   delay_count, delay_count_next;
  logic [CntW-1:0]   blank_count, blank_count_next;

  logic              out_valid_next;
  hsct_out_t         result;

  logic [CntW-1:0]   quot_x60, rem_full;
  logic [FirstW-1:0] rem60;
  logic [SecW-1:0]   left, elapsed;
  logic [CntW-1:0]   delay_x2;

  assign stage_take     = ~out_valid | ~out_stall;
  assign fire           = stage_valid & stage_take;
  assign out_valid_next = fire | (out_valid & out_stall);

  // seconds mod 60 from the registered quotient: 60q = 64q - 4q
  assign quot_x60 = {stage_word.quot, 6'd0} - {4'd0, stage_word.quot, 2'd0};
  assign rem_full = {1'b0, stage_word.seconds} - quot_x60;
  assign rem60    = rem_full[FirstW-1:0];
  assign delay_x2 = {1'b0, cfg_delay, 1'b0};

  always_comb begin
    generic_count_next  = generic_count;
    generic_flag_next   = generic_flag;
    run_count_next      = run_count;
    run_start_next      = run_start;
    first_interval_next = first_interval;
    run_paused_next     = run_paused;
    restart_window_next = restart_window;
    display_flag_next   = display_flag;
    selftest_flag_next  = selftest_flag;
    tick_phase_next     = tick_phase;
    saver_enabled_next  = saver_enabled;
    saver_count_next    = saver_count;
    delay_count_next    = delay_count;
    blank_count_next    = blank_count;
    result.saver_start  = 1'b0;
    result.screen_blank = 1'b0;

    if (fire) begin
      case (stage_word.op)
        OP_TICK: begin
          if (generic_count != '0) begin
            generic_count_next = generic_count - CntW'(1);
            if (generic_count == CntW'(1)) begin
              generic_flag_next = 1'b1;
            end
          end
          if (!run_paused && run_count != '0) begin
            run_count_next = run_count - CntW'(1);
            // odd count now means an even count after the decrement
            if (run_count[0]) begin
              display_flag_next = 1'b1;
            end
            if (restart_window != '0) begin
              restart_window_next = restart_window - WinW'(1);
            end
          end
          if (!tick_phase) begin
            selftest_flag_next = 1'b1;
          end
          tick_phase_next = ~tick_phase;
          if (saver_enabled && saver_count != SaverMax) begin
            saver_count_next = saver_count + CntW'(1);
            if (saver_count_next == delay_count) begin
              result.saver_start = 1'b1;
            end else if (saver_count_next == blank_count) begin
              result.screen_blank = 1'b1;
            end
          end
        end
        OP_START_GENERIC: begin
          generic_count_next = {stage_word.seconds, 1'b0};
        end
        OP_CLEAR_GENERIC: begin
          generic_count_next = '0;
        end
        OP_START_RUN: begin
          display_flag_next   = 1'b0;
          run_count_next      = {stage_word.seconds, 1'b1};
          run_start_next      = stage_word.seconds;
          first_interval_next = (rem60 == '0) ? MinuteSeconds : rem60;
          run_paused_next     = 1'b0;
          restart_window_next = RestartTicks;
        end
        OP_PAUSE: begin
          run_paused_next = 1'b1;
        end
        OP_RESUME: begin
          run_paused_next     = 1'b0;
          restart_window_next = RestartTicks;
        end
        OP_SAVER_RESTART: begin
          saver_enabled_next = 1'b1;
          saver_count_next   = '0;
          delay_count_next   = delay_x2;
          blank_count_next   = delay_x2 + {1'b0, cfg_length, 1'b0};
        end
        OP_SAVER_STOP: begin
          saver_enabled_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // flags are reported before a read clears them
    result.generic_done = generic_flag_next;
    result.display_due  = display_flag_next;
    result.selftest_due = selftest_flag_next;

    if (fire) begin
      case (stage_word.op)
        OP_READ_GENERIC:  generic_flag_next  = 1'b0;
        OP_READ_DISPLAY:  display_flag_next  = 1'b0;
        OP_READ_SELFTEST: selftest_flag_next = 1'b0;
        default: begin
        end
      endcase
    end

    left    = run_count_next[CntW-1:1];
    elapsed = (run_start_next >= left) ? (run_start_next - left) : '0;
    result.seconds_left    = left;
    result.early_interval  = (elapsed < {{(SecW-FirstW){1'b0}}, first_interval_next});
    result.newly_restarted = (restart_window_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_delay  <= '0;
      cfg_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAVER_DELAY:  cfg_delay  <= cfg_data;
        CFG_SAVER_LENGTH: cfg_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generic_count  <= '0;
      generic_flag   <= 1'b0;
      run_count      <= '0;
      run_start      <= '0;
      first_interval <= '0;
      run_paused     <= 1'b1;
      restart_window <= '0;
      display_flag   <= 1'b0;
      selftest_flag  <= 1'b0;
      tick_phase     <= 1'b0;
      saver_enabled  <= 1'b0;
      saver_count    <= '0;
      delay_count    <= '0;
      blank_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      generic_count  <= generic_count_next;
      generic_flag   <= generic_flag_next;
      run_count      <= run_count_next;
      run_start      <= run_start_next;
      first_interval <= first_interval_next;
      run_paused     <= run_paused_next;
      restart_window <= restart_window_next;
      display_flag   <= display_flag_next;
      selftest_flag  <= selftest_flag_next;
      tick_phase     <= tick_phase_next;
      saver_enabled  <= saver_enabled_next;
      saver_count    <= saver_count_next;
      delay_count    <= delay_count_next;
      blank_count    <= blank_count_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

endmodule

`default_nettype wire

/* hdl/half_second_countdown_timers_unit.sv */
// Half-second countdown timers. Each input word is one event: a tick (one
// half-second), start or clear of the generic countdown, start, pause or
// resume of the run countdown, screensaver restart or stop, or a read that
// clears the generic, display or self-test flag. Every accepted word yields
// exactly one result word showing the state after the event; a read reports
// its flag as it was before the clear. saver_start and screen_blank are
// one-word pulses that only a tick can raise. One word is taken per clock
// while no result is stalled; each passes the input register (which also
// holds the precomputed quotient by 60 used for the first partial minute),
// then the result register. While a result is stalled, one more word is
// absorbed by the input register before in_stall rises. Saver delay and
// length are sampled only on a saver restart; the user must write them via
// cfg_we/cfg_index/cfg_data while no word is in flight; not enforced.
`default_nettype none

module half_second_countdown_timers_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire hsct_pkg::hsct_in_t           in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output hsct_pkg::hsct_out_t               out_word,
  input  wire logic                         cfg_we,
  input  wire logic [hsct_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hsct_pkg::CfgW-1:0]    cfg_data
);
  import hsct_pkg::*;

  // input register -> event logic and state -> result register
  logic        stage_valid;
  logic        stage_take;
  hsct_stage_t stage_word;

  hsct_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .stage_valid (stage_valid),
    .stage_word  (stage_word),
    .stage_take  (stage_take)
  );

  hsct_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_word  (stage_word),
    .stage_take  (stage_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

`default_nettype wire

/* hdl/hsct_checker.sv */
`default_nettype none

module hsct_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire hsct_pkg::hsct_out_t          out_word
);
  import hsct_pkg::*;

  logic in_accept;

  assign in_accept = in_valid & ~in_stall;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // the two saver pulses are exclusive
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.saver_start && out_word.screen_blank))
    else $error("saver_start and screen_blank together");

  // once an accepted word has passed the input register, the result register holds a word
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ##1 out_valid)
    else $error("accepted word produced no result");

endmodule

bind half_second_countdown_timers_unit hsct_checker u_hsct_checker (.*);

`default_nettype wire
